@@ hw/rtl/sptd_pkg.sv @@
package sptd_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [3:0] POS_FIRST  = 4'd0;
  localparam logic [3:0] POS_TEMP_HI = 4'd1;
  localparam logic [3:0] POS_CONFIG = 4'd4;
  localparam logic [3:0] POS_CRC    = 4'd8;
  localparam logic [3:0] POS_DONE   = 4'd9;

  localparam logic [1:0] RES_9BIT  = 2'd0;
  localparam logic [1:0] RES_10BIT = 2'd1;
  localparam logic [1:0] RES_11BIT = 2'd2;
  localparam logic [1:0] RES_12BIT = 2'd3;

  localparam int RES_LSB = 5;

  // reflected 1-Wire CRC-8, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[0];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

  function automatic logic [15:0] res_mask(input logic [1:0] res);
    logic [15:0] m;
    case (res)
      RES_9BIT:  m = 16'hFFF8;
      RES_10BIT: m = 16'hFFFC;
      RES_11BIT: m = 16'hFFFE;
      RES_12BIT: m = 16'hFFFF;
      default:   m = 16'hFFFF;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/sptd_if.sv @@
interface sptd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scratch_byte;
  logic       frame_start;

  modport source (output valid, output scratch_byte, output frame_start, input ready);
  modport sink   (input valid, input scratch_byte, input frame_start, output ready);
endinterface

interface sptd_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_sixteenths;
  logic        [1:0]  resolution_code;
  logic        [7:0]  crc_computed;
  logic               crc_match;

  modport source (output valid, output temperature_sixteenths, output resolution_code,
                  output crc_computed, output crc_match, input ready);
  modport sink   (input valid, input temperature_sixteenths, input resolution_code,
                  input crc_computed, input crc_match, output ready);
endinterface

@@ hw/rtl/scratchpad_temp_decode_crc8.sv @@
// A result word is registered and appears in the cycle after the CRC byte (byte 8) is accepted.
// Throughput: one byte word per cycle while byte_in.ready is high; the byte-wide CRC update is one XOR network.
// The output register lets a new byte in while a result waits, and stalls input
// only when the held result is not taken.
// Reset (rst, synchronous, active high): byte position, CRC, captured bytes and
// output valid clear.
module scratchpad_temp_decode_crc8
  import sptd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sptd_byte_if.sink     byte_in,
  sptd_result_if.source result_out
);

  logic [3:0] byte_position;
  logic [7:0] crc_accumulator;
  logic [7:0] temp_low_byte;
  logic [7:0] temp_high_byte;
  logic [1:0] resolution_bits;

  logic               out_valid;
  logic signed [15:0] out_temp;
  logic        [1:0]  out_res;
  logic        [7:0]  out_crc;
  logic               out_match;

  logic       accept;
  logic [3:0] pos_eff;
  logic [7:0] crc_eff;
  logic [7:0] crc_next;
  logic [15:0] temp_masked;

  assign byte_in.ready = !out_valid || result_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  assign pos_eff     = byte_in.frame_start ? POS_FIRST : byte_position;
  assign crc_eff     = byte_in.frame_start ? 8'h00 : crc_accumulator;
  assign crc_next    = crc8_byte(crc_eff, byte_in.scratch_byte);
  assign temp_masked = {temp_high_byte, temp_low_byte} & res_mask(resolution_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_FIRST;
      crc_accumulator <= 8'h00;
      temp_low_byte   <= 8'h00;
      temp_high_byte  <= 8'h00;
      resolution_bits <= RES_9BIT;
      out_valid       <= 1'b0;
    end else begin
      if (accept && pos_eff == POS_CRC) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (pos_eff < POS_CRC) begin
          crc_accumulator <= crc_next;
          byte_position   <= pos_eff + 4'd1;
          if (pos_eff == POS_FIRST) begin
            temp_low_byte <= byte_in.scratch_byte;
          end else if (pos_eff == POS_TEMP_HI) begin
            temp_high_byte <= byte_in.scratch_byte;
          end else if (pos_eff == POS_CONFIG) begin
            resolution_bits <= byte_in.scratch_byte[RES_LSB +: 2];
          end
        end else begin
          byte_position <= POS_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos_eff == POS_CRC) begin
      out_temp  <= signed'(temp_masked);
      out_res   <= resolution_bits;
      out_crc   <= crc_accumulator;
      out_match <= (crc_accumulator == byte_in.scratch_byte);
    end
  end

  assign result_out.valid                  = out_valid;
  assign result_out.temperature_sixteenths = out_temp;
  assign result_out.resolution_code        = out_res;
  assign result_out.crc_computed           = out_crc;
  assign result_out.crc_match              = out_match;

endmodule

@@ tb/scratchpad_temp_decode_crc8_tb.sv @@
module scratchpad_temp_decode_crc8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sptd_pkg::*;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [1:0]         res;
    logic [7:0]         crc;
    logic               match;
  } reading_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       has_listed;
    reading_t   listed;
  } stim_row_t;

  localparam reading_t NO_READING     = '0;
  localparam reading_t ZERO_FRAME_OK  = '{16'sd0, RES_9BIT, 8'h00, 1'b1};
  localparam reading_t ZERO_FRAME_BAD = '{16'sd0, RES_9BIT, 8'h00, 1'b0};
  localparam int       NUM_DIRECTED   = 22;
  localparam int       RANDOM_WORDS   = 1500;

  // all-zero frame without a start flag, a word past the end, a dropped partial frame,
  // then an all-zero frame whose CRC byte is wrong
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b0, 1'b1, ZERO_FRAME_OK},
    '{8'hFF, 1'b0, 1'b0, NO_READING},
    '{8'hFF, 1'b1, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
    '{8'h80, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b1, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
    '{8'hFF, 1'b0, 1'b1, ZERO_FRAME_BAD}
  };

  logic clk;
  logic rst;
  logic quiet;
  logic word_has_listed;
  reading_t word_listed;
  int mismatch_count;

  logic [3:0] frame_pos;
  logic [7:0] crc_run;
  logic [7:0] temp_lo;
  logic [7:0] temp_hi;
  logic [1:0] res_code;

  reading_t pending_readings[$];

  sptd_byte_if   byte_bus();
  sptd_result_if result_bus();

  scratchpad_temp_decode_crc8 dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_bus),
    .result_out (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ d[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit decode_word(input logic [7:0] b, input logic st,
                                     output reading_t r);
    logic [15:0] raw;
    r = NO_READING;
    if (st) begin
      frame_pos = POS_FIRST;
      crc_run = '0;
    end
    if (frame_pos >= POS_DONE) begin
      frame_pos = POS_DONE;
      return 1'b0;
    end
    if (frame_pos != POS_CRC) begin
      crc_run = crc_step(crc_run, b);
      case (frame_pos)
        POS_FIRST:   temp_lo = b;
        POS_TEMP_HI: temp_hi = b;
        POS_CONFIG:  res_code = b[RES_LSB +: 2];
        default: ;
      endcase
      frame_pos = frame_pos + 4'd1;
      return 1'b0;
    end
    raw = {temp_hi, temp_lo};
    case (res_code)
      RES_9BIT:  raw[2:0] = '0;
      RES_10BIT: raw[1:0] = '0;
      RES_11BIT: raw[0] = 1'b0;
      default: ;
    endcase
    r = '{raw, res_code, crc_run, (crc_run == b)};
    frame_pos = POS_DONE;
    return 1'b1;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [7:0] b, input logic st, input logic has_listed,
                           input reading_t listed);
    while (!quiet && $urandom_range(99) < 15) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk);
    end
    byte_bus.valid        <= 1'b1;
    byte_bus.scratch_byte <= b;
    byte_bus.frame_start  <= st;
    word_has_listed       <= has_listed;
    word_listed           <= listed;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_readings();
    byte_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_readings.size() != 0);
  endtask

  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_bus.ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin : watch
    reading_t want;
    if (!rst) begin
      if (byte_bus.valid && byte_bus.ready) begin
        if (decode_word(byte_bus.scratch_byte, byte_bus.frame_start, want)) begin
          pending_readings.push_back(word_has_listed ? word_listed : want);
        end
      end
      if (result_bus.valid && result_bus.ready) begin
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected reading: temp %0d res %0d crc %02h match %0b", $time,
                   result_bus.temperature_sixteenths, result_bus.resolution_code,
                   result_bus.crc_computed, result_bus.crc_match);
          mismatch_count++;
        end else begin
          want = pending_readings.pop_front();
          if (result_bus.temperature_sixteenths !== want.temp) begin
            $display("%0t: temperature: expected %0d, got %0d", $time, want.temp,
                     result_bus.temperature_sixteenths);
            mismatch_count++;
          end
          if (result_bus.resolution_code !== want.res) begin
            $display("%0t: resolution: expected %0d, got %0d", $time, want.res,
                     result_bus.resolution_code);
            mismatch_count++;
          end
          if (result_bus.crc_computed !== want.crc) begin
            $display("%0t: crc: expected %02h, got %02h", $time, want.crc,
                     result_bus.crc_computed);
            mismatch_count++;
          end
          if (result_bus.crc_match !== want.match) begin
            $display("%0t: crc match: expected %0b, got %0b", $time, want.match,
                     result_bus.crc_match);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  frame [9];
    logic [15:0] tw;
    logic [7:0]  crc;
    logic        st;
    int          words_sent;
    int          pick;
    int          n;
    bit          drained_mid;

    rst                   = 1'b1;
    quiet                 = 1'b0;
    byte_bus.valid        = 1'b0;
    byte_bus.scratch_byte = '0;
    byte_bus.frame_start  = 1'b0;
    word_has_listed       = 1'b0;
    word_listed           = NO_READING;
    mismatch_count        = 0;
    frame_pos             = POS_FIRST;
    crc_run               = '0;
    temp_lo               = '0;
    temp_hi               = '0;
    res_code              = RES_9BIT;
    words_sent            = 0;
    drained_mid           = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_word(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].has_listed,
                DIRECTED_ROWS[i].listed);
    end
    drain_readings();

    while (words_sent < RANDOM_WORDS) begin
      quiet = (words_sent >= 600 && words_sent < 900);
      if (!drained_mid && words_sent >= 1000) begin
        drain_readings();
        drained_mid = 1'b1;
      end

      case ($urandom_range(5))
        0:       tw = 16'h0000;
        1:       tw = 16'hFFFF;
        2:       tw = 16'h7FFF;
        3:       tw = 16'h8000;
        4:       tw = 16'($urandom_range(128)) - 16'd64;
        default: tw = 16'($urandom);
      endcase
      frame[0] = tw[7:0];
      frame[1] = tw[15:8];
      for (int k = 2; k < 8; k++) frame[k] = 8'($urandom_range(255));
      crc = '0;
      for (int k = 0; k < 8; k++) crc = crc_step(crc, frame[k]);
      frame[8] = ($urandom_range(99) < 70) ? crc : 8'($urandom_range(255));

      pick = $urandom_range(99);
      if (pick < 80) begin
        for (int k = 0; k < 9; k++) send_word(frame[k], k == 0, 1'b0, NO_READING);
        words_sent += 9;
      end else if (pick < 88) begin
        // partial frame, dropped by the next start
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) send_word(frame[k], k == 0, 1'b0, NO_READING);
        words_sent += n;
      end else if (pick < 95) begin
        for (int k = 0; k < 9; k++) send_word(frame[k], k == 0, 1'b0, NO_READING);
        words_sent += 9;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) send_word(8'($urandom_range(255)), 1'b0, 1'b0, NO_READING);
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          st = 1'($urandom_range(1));
          send_word(8'($urandom_range(255)), st, 1'b0, NO_READING);
          if (st) words_sent++;
        end
      end
    end
    quiet = 1'b0;

    drain_readings();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
